// ===== design/lbs_pkg.sv =====
// Package for the linear blend skinning engine: item types, sequencer states,
// pipeline control structs and sizing constants. No dependencies.
`default_nettype none

package lbs_pkg;

  // default sizing handed to the top level
  localparam int MAX_BONES_DEF  = 64;
  localparam int INFLUENCES_DEF = 4;

  // fixed geometry of the work
  localparam int MAT_WORDS = 12;      // 3x4 affine matrix
  localparam int ROW_WORDS = 4;
  localparam int VEC_ROWS  = 3;
  localparam int BONE_W    = 6;
  localparam int WEIGHT_W  = 16;
  localparam int DEST_W    = 4;

  // fixed-point scale of 1.0 in Q16.16 (w = 1 for the position)
  localparam logic signed [32:0] ONE_Q16 = 33'sd65536;

  // item operation codes
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_SKIN = 1'b1
  } lbs_opcode_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BLEND,
    ST_BDRAIN,
    ST_XFORM,
    ST_XDRAIN,
    ST_DONE
  } lbs_state_e;

  typedef struct packed {
    logic               operation;
    logic [5:0]         load_bone;
    logic [3:0]         load_element;
    logic signed [31:0] load_value;
    logic [23:0]        bone_ids;
    logic [63:0]        bone_weights;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] norm_x;
    logic signed [31:0] norm_y;
    logic signed [31:0] norm_z;
  } lbs_in_t;

  typedef struct packed {
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_norm_x;
    logic signed [31:0] out_norm_y;
    logic signed [31:0] out_norm_z;
  } lbs_out_t;

  // control that travels with one product through the mac pipeline
  typedef struct packed {
    logic              valid;
    logic              first;  // clears the accumulator
    logic              last;   // accumulator complete after this term
    logic              blend;  // blend sum (Q.31) vs transform sum (Q.32)
    logic [DEST_W-1:0] dest;   // blend element or result index
  } lbs_op_t;

  // rounded and saturated sum leaving the mac
  typedef struct packed {
    logic               valid;
    logic               blend;
    logic [DEST_W-1:0]  dest;
    logic signed [31:0] value;
  } lbs_res_t;

endpackage

`default_nettype wire

// ===== design/lbs_stream_if.sv =====
// Valid/ready stream interface carrying one payload of type T.
// Used for the input and result channels of the skinning engine.
`default_nettype none

interface lbs_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/lbs_mac.sv =====
// Shared multiply-accumulate unit of the skinning engine: registered 33x33
// product, 68-bit accumulator, round and saturate to Q16.16. Uses lbs_pkg.
`default_nettype none

module lbs_mac (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire lbs_pkg::lbs_op_t   op_i,
  input  wire logic signed [31:0] a_i,
  input  wire logic signed [32:0] b_i,
  output      lbs_pkg::lbs_res_t  res_o,
  output      logic               busy_o
);
  import lbs_pkg::*;

  localparam int PROD_W = 66;
  localparam int ACC_W  = 68;

  lbs_op_t                   op_p_q;
  lbs_op_t                   op_a_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [32:0]        a_ext;
  logic signed [ACC_W-1:0]   rnd;
  logic signed [ACC_W-1:0]   shf;
  logic signed [31:0]        sat;

  assign a_ext = 33'(a_i);

  // control valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_p_q <= '0;
      op_a_q <= '0;
    end else begin
      op_p_q <= op_i;
      op_a_q <= op_p_q;
    end
  end

  // product then accumulate
  always_ff @(posedge clk_i) begin
    if (op_i.valid) begin
      prod_q <= a_ext * b_i;
    end
    if (op_p_q.valid) begin
      acc_q <= (op_p_q.first ? '0 : acc_q) + ACC_W'(prod_q);
    end
  end

  // round half up and saturate to signed 32 bits
  always_comb begin
    rnd = acc_q + (op_a_q.blend ? 68'sd16384 : 68'sd32768);
    shf = op_a_q.blend ? (rnd >>> 15) : (rnd >>> 16);
    if (shf > 68'sd2147483647) begin
      sat = 32'sh7fffffff;
    end else if (shf < -68'sd2147483648) begin
      sat = 32'sh80000000;
    end else begin
      sat = shf[31:0];
    end
  end

  assign res_o.valid = op_a_q.valid && op_a_q.last;
  assign res_o.blend = op_a_q.blend;
  assign res_o.dest  = op_a_q.dest;
  assign res_o.value = sat;
  assign busy_o      = op_p_q.valid || op_a_q.valid;

endmodule

`default_nettype wire

// ===== design/linear_blend_skinning.sv =====
// Top level of the four-influence linear blend skinning engine.
// Depends on lbs_pkg, lbs_stream_if and lbs_mac.
`default_nettype none

// Load items write one Q16.16 element of a bone's 3x4 matrix into an on-chip
// store of MAX_BONES*12 words; no result is produced.
// Elements must be written before any vertex reads them. A vertex item
// blends INFLUENCES bone matrices by their Q1.15 weights (no renormalization),
// then transforms the position (w=1) and the normal (w=0), and produces one
// saturated Q16.16 result. All products go through a single multiply-
// accumulate unit, one product per cycle: 12*INFLUENCES blend products plus
// 21 transform products; the pipeline drains after each phase. The input is
// not ready while a vertex is in work; a finished result waits in the output
// register while the next item is taken, and the next vertex holds in its
// done state for as long as that register is still full.
module linear_blend_skinning #(
  parameter int MAX_BONES  = lbs_pkg::MAX_BONES_DEF,
  parameter int INFLUENCES = lbs_pkg::INFLUENCES_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lbs_stream_if.sink   in_i,
  lbs_stream_if.source out_o
);
  import lbs_pkg::*;

  localparam int DEPTH = MAX_BONES * MAT_WORDS;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = (INFLUENCES > 1) ? $clog2(INFLUENCES) : 1;

  lbs_state_e state_q, state_d;

  lbs_in_t                 vtx_q;
  logic [3:0]              elem_q;
  logic [IW-1:0]           infl_q;
  logic                    vec_q;
  logic [1:0]              row_q;
  logic [1:0]              col_q;

  logic signed [31:0]      mem_q [DEPTH];
  logic signed [31:0]      rd_q;
  logic signed [31:0]      blend_q [MAT_WORDS];
  logic signed [31:0]      res_q [2*VEC_ROWS];

  logic                    out_valid_q;
  lbs_out_t                out_data_q;

  // issue stage outputs
  lbs_op_t                 iss_op;
  logic [AW-1:0]           rd_addr;
  logic signed [31:0]      iss_a;
  logic signed [32:0]      iss_b;
  logic                    iss_mem;
  logic                    iss_zero;
  logic [BONE_W-1:0]       cur_bone;
  logic [WEIGHT_W-1:0]     cur_weight;
  logic signed [31:0]      cur_comp;
  logic                    in_ready;
  logic                    out_load;

  // operand stage (memory read data lines up here)
  lbs_op_t                 s1_op_q;
  logic signed [31:0]      s1_a_q;
  logic signed [32:0]      s1_b_q;
  logic                    s1_mem_q;
  logic                    s1_zero_q;
  logic signed [31:0]      mac_a;

  lbs_res_t                mac_res;
  logic                    mac_busy;
  logic                    pipe_busy;

  logic                    in_xfer;
  logic                    load_xfer;
  logic                    skin_xfer;
  logic                    blend_last;
  logic                    xform_last;

  assign in_xfer   = in_i.valid && in_ready;
  assign load_xfer = in_xfer && (in_i.data.operation == OP_LOAD);
  assign skin_xfer = in_xfer && (in_i.data.operation == OP_SKIN);
  assign pipe_busy = s1_op_q.valid || mac_busy;

  assign blend_last = (32'(infl_q) == INFLUENCES - 1);
  assign xform_last = (vec_q == 1'b0) ? (col_q == 2'd3) : (col_q == 2'd2);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (skin_xfer) state_d = ST_BLEND;
      ST_BLEND:  if (blend_last && (elem_q == 4'(MAT_WORDS - 1))) state_d = ST_BDRAIN;
      ST_BDRAIN: if (!pipe_busy) state_d = ST_XFORM;
      ST_XFORM:  if (xform_last && vec_q && (row_q == 2'(VEC_ROWS - 1))) state_d = ST_XDRAIN;
      ST_XDRAIN: if (!pipe_busy) state_d = ST_DONE;
      ST_DONE:   if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // operand selection for the current step
  always_comb begin
    cur_bone   = vtx_q.bone_ids[32'(infl_q) * BONE_W +: BONE_W];
    cur_weight = vtx_q.bone_weights[32'(infl_q) * WEIGHT_W +: WEIGHT_W];
    unique case ({vec_q, col_q})
      3'b000:  cur_comp = vtx_q.pos_x;
      3'b001:  cur_comp = vtx_q.pos_y;
      3'b010:  cur_comp = vtx_q.pos_z;
      3'b100:  cur_comp = vtx_q.norm_x;
      3'b101:  cur_comp = vtx_q.norm_y;
      3'b110:  cur_comp = vtx_q.norm_z;
      default: cur_comp = '0;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = (state_q == ST_IDLE);
    out_load = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);
    iss_op   = '0;
    iss_a    = blend_q[{row_q, col_q}];
    iss_b    = (col_q == 2'd3) ? ONE_Q16 : 33'(cur_comp);
    iss_mem  = 1'b0;
    iss_zero = 1'b0;
    rd_addr  = AW'(32'(cur_bone) * MAT_WORDS + 32'(elem_q));
    unique case (state_q)
      ST_BLEND: begin
        iss_op.valid = 1'b1;
        iss_op.first = (infl_q == '0);
        iss_op.last  = blend_last;
        iss_op.blend = 1'b1;
        iss_op.dest  = elem_q;
        iss_b        = {17'd0, cur_weight};
        iss_mem      = 1'b1;
        iss_zero     = !(32'(cur_bone) < MAX_BONES);
      end
      ST_XFORM: begin
        iss_op.valid = 1'b1;
        iss_op.first = (col_q == 2'd0);
        iss_op.last  = xform_last;
        iss_op.blend = 1'b0;
        iss_op.dest  = DEST_W'(32'(vec_q) * VEC_ROWS + 32'(row_q));
      end
      default: ;
    endcase
  end

  // state and step counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      elem_q  <= '0;
      infl_q  <= '0;
      vec_q   <= 1'b0;
      row_q   <= '0;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      if (skin_xfer) begin
        elem_q <= '0;
        infl_q <= '0;
        vec_q  <= 1'b0;
        row_q  <= '0;
        col_q  <= '0;
      end else if (state_q == ST_BLEND) begin
        if (blend_last) begin
          infl_q <= '0;
          elem_q <= elem_q + 4'd1;
        end else begin
          infl_q <= infl_q + 1'b1;
        end
      end else if (state_q == ST_XFORM) begin
        if (xform_last) begin
          col_q <= '0;
          if (row_q == 2'(VEC_ROWS - 1)) begin
            row_q <= '0;
            vec_q <= 1'b1;
          end else begin
            row_q <= row_q + 2'd1;
          end
        end else begin
          col_q <= col_q + 2'd1;
        end
      end
    end
  end

  // vertex capture
  always_ff @(posedge clk_i) begin
    if (skin_xfer) begin
      vtx_q <= in_i.data;
    end
  end

  // bone matrix store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (load_xfer && (32'(in_i.data.load_bone) < MAX_BONES) &&
        (in_i.data.load_element < 4'(MAT_WORDS))) begin
      mem_q[AW'(32'(in_i.data.load_bone) * MAT_WORDS + 32'(in_i.data.load_element))]
        <= in_i.data.load_value;
    end
    rd_q <= mem_q[rd_addr];
  end

  // operand stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_op_q <= '0;
    end else begin
      s1_op_q <= iss_op;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_a_q    <= iss_a;
    s1_b_q    <= iss_b;
    s1_mem_q  <= iss_mem;
    s1_zero_q <= iss_zero;
  end

  assign mac_a = s1_zero_q ? '0 : (s1_mem_q ? rd_q : s1_a_q);

  lbs_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (s1_op_q),
    .a_i    (mac_a),
    .b_i    (s1_b_q),
    .res_o  (mac_res),
    .busy_o (mac_busy)
  );

  // write back finished sums
  always_ff @(posedge clk_i) begin
    if (mac_res.valid) begin
      if (mac_res.blend) begin
        blend_q[mac_res.dest] <= mac_res.value;
      end else begin
        res_q[3'(mac_res.dest)] <= mac_res.value;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.out_pos_x  <= res_q[0];
      out_data_q.out_pos_y  <= res_q[1];
      out_data_q.out_pos_z  <= res_q[2];
      out_data_q.out_norm_x <= res_q[3];
      out_data_q.out_norm_y <= res_q[4];
      out_data_q.out_norm_z <= res_q[5];
    end
  end

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // the pipeline is empty whenever a new item can be taken
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pipe_busy)
    else $error("mac pipeline busy while idle");

  // blend sums only complete during the blend phase
  a_blend_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mac_res.valid && mac_res.blend) |-> (state_q == ST_BLEND || state_q == ST_BDRAIN))
    else $error("blend write back outside blend phase");

  // a result shows up only out of the done state
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised outside done state");

  // blend element counter stays inside the matrix
  a_elem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BLEND) |-> (elem_q < 4'(MAT_WORDS)))
    else $error("blend element index out of range");

endmodule

`default_nettype wire
